// ===== rtl/lz4bd_pkg.sv =====
package lz4bd_pkg;

	localparam int PHASE_W = 3;

	localparam logic [PHASE_W-1:0] PH_TOKEN     = 3'd0;
	localparam logic [PHASE_W-1:0] PH_LIT_EXT   = 3'd1;
	localparam logic [PHASE_W-1:0] PH_LITERALS  = 3'd2;
	localparam logic [PHASE_W-1:0] PH_OFF_LO    = 3'd3;
	localparam logic [PHASE_W-1:0] PH_OFF_HI    = 3'd4;
	localparam logic [PHASE_W-1:0] PH_MATCH_EXT = 3'd5;
	localparam logic [PHASE_W-1:0] PH_MATCH     = 3'd6;

	localparam logic CMD_BYTE    = 1'b0;
	localparam logic CMD_ADVANCE = 1'b1;

	localparam int LEN_W = 24;

	localparam logic [LEN_W-1:0] LIMIT_RESET = 24'd65536;
	localparam logic [3:0]       NIBBLE_MAX  = 4'd15;
	localparam logic [7:0]       EXT_MORE    = 8'd255;
	localparam logic [LEN_W-1:0] MIN_MATCH   = 24'd4;

	typedef struct packed {
		logic             pending;
		logic             done;
		logic             err;
		logic [LEN_W-1:0] total;
	} status_t;

endpackage

// ===== rtl/lz4_block_decompressor.sv =====
// channel  | valid     | stall     | payload
// request  | cmd_valid | cmd_stall | command, in_byte, block_end
// result   | res_valid | res_stall | out_byte, out_valid, match_pending, done_res, error,
//          |           |           | total_written
// config   | cfg_wr_en | -         | cfg_wr_data (output_limit)
//
// one request per cycle unless stalled; results pass stage one, then the result register
// history is one ram port pair: read at request, write as it leaves stage one, forwarded
// arst_n clears parse state and loads limit 65536; history needs no clearing
// cmd_stall rises only when the result register is full and res_stall holds it
module lz4_block_decompressor #(
	parameter int WINDOW_BYTES = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [23:0] cfg_wr_data,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic        command,
	input  logic [7:0]  in_byte,
	input  logic        block_end,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [7:0]  out_byte,
	output logic        out_valid,
	output logic        match_pending,
	output logic        done_res,
	output logic        error,
	output logic [23:0] total_written
);

	localparam int AW = $clog2(WINDOW_BYTES);
	localparam logic [16:0] WIN17 = 17'(WINDOW_BYTES);
	localparam logic [AW-1:0] PTR_LAST = AW'(WINDOW_BYTES - 1);

	logic [23:0] limit_q;
	logic [lz4bd_pkg::PHASE_W-1:0] phase_q, n_phase;
	logic [23:0] lit_q, n_lit;
	logic [23:0] ml_q, n_ml;
	logic [3:0]  nib_q, n_nib;
	logic [15:0] dist_q, n_dist;
	logic [23:0] bw_q, n_bw;
	logic [AW-1:0] ptr_q, n_ptr;
	logic err_q, n_err;
	logic end_q, n_end;

	logic accept;
	logic wr_byte, wr_match;
	logic [AW-1:0] wr_addr;
	logic [24:0] lit_sum, ml_sum, ml_sum4;
	logic [16:0] src_diff;
	logic [AW-1:0] rd_addr;
	lz4bd_pkg::status_t n_status;

	logic          s1_v_q, s1_wr_q, s1_match_q, s1_fwd_q;
	logic [7:0]    s1_lit_s1, s1_fwd_data_s1;
	logic [AW-1:0] s1_addr_s1;
	lz4bd_pkg::status_t s1_status_s1;
	logic          s1_move;
	logic [7:0]    s1_data;
	logic [7:0]    ram_rdata;

	logic          out_v_q, out_wr_q;
	logic [7:0]    out_byte_q;
	lz4bd_pkg::status_t out_status_q;

	assign s1_move   = s1_v_q && (!out_v_q || !res_stall);
	assign cmd_stall = s1_v_q && !s1_move;
	assign accept    = cmd_valid && !cmd_stall;

	assign src_diff = 17'(ptr_q) - {1'b0, dist_q};
	assign rd_addr  = src_diff[16] ? AW'(src_diff + WIN17) : AW'(src_diff);

	always_comb begin
		n_phase = phase_q;
		n_lit   = lit_q;
		n_ml    = ml_q;
		n_nib   = nib_q;
		n_dist  = dist_q;
		n_bw    = bw_q;
		n_ptr   = ptr_q;
		n_err   = err_q;
		n_end   = end_q;
		wr_byte = 1'b0;
		wr_match = 1'b0;
		wr_addr = ptr_q;
		lit_sum = '0;
		ml_sum  = '0;
		ml_sum4 = '0;
		if (accept) begin
			if (command == lz4bd_pkg::CMD_BYTE) begin
				if (end_q) begin
					n_bw    = '0;
					n_ptr   = '0;
					n_err   = 1'b0;
					n_end   = 1'b0;
					n_phase = lz4bd_pkg::PH_TOKEN;
					n_lit   = '0;
					n_ml    = '0;
					n_nib   = '0;
					n_dist  = '0;
				end
				if (n_err) begin
					if (block_end) begin
						n_end = 1'b1;
					end
				end else if (n_phase != lz4bd_pkg::PH_MATCH) begin
					case (n_phase)
						lz4bd_pkg::PH_TOKEN: begin
							n_lit = 24'(in_byte[7:4]);
							n_nib = in_byte[3:0];
							if (in_byte[7:4] == lz4bd_pkg::NIBBLE_MAX) begin
								n_phase = lz4bd_pkg::PH_LIT_EXT;
							end else if (in_byte[7:4] != 4'd0) begin
								n_phase = lz4bd_pkg::PH_LITERALS;
							end else begin
								n_phase = lz4bd_pkg::PH_OFF_LO;
							end
						end
						lz4bd_pkg::PH_LIT_EXT: begin
							lit_sum = {1'b0, n_lit} + 25'(in_byte);
							if (lit_sum[24]) begin
								n_err = 1'b1; n_phase = lz4bd_pkg::PH_TOKEN;
								n_lit = '0; n_ml = '0;
							end else begin
								n_lit = lit_sum[23:0];
								if (in_byte != lz4bd_pkg::EXT_MORE) begin
									n_phase = lz4bd_pkg::PH_LITERALS;
								end
							end
						end
						lz4bd_pkg::PH_LITERALS: begin
							if (n_bw >= limit_q) begin
								n_err = 1'b1; n_phase = lz4bd_pkg::PH_TOKEN;
								n_lit = '0; n_ml = '0;
							end else begin
								wr_byte = 1'b1;
								wr_addr = n_ptr;
								n_bw    = n_bw + 24'd1;
								n_ptr   = (n_ptr == PTR_LAST) ? '0 : n_ptr + AW'(1);
								if (n_lit == 24'd1) begin
									n_phase = lz4bd_pkg::PH_OFF_LO;
								end
								n_lit = n_lit - 24'd1;
							end
						end
						lz4bd_pkg::PH_OFF_LO: begin
							n_dist  = {8'h00, in_byte};
							n_phase = lz4bd_pkg::PH_OFF_HI;
						end
						lz4bd_pkg::PH_OFF_HI: begin
							n_dist = {in_byte, n_dist[7:0]};
							if (n_dist == 16'd0 || 24'(n_dist) > n_bw
									|| 17'(n_dist) > WIN17) begin
								n_err = 1'b1; n_phase = lz4bd_pkg::PH_TOKEN;
								n_lit = '0; n_ml = '0;
							end else if (n_nib == lz4bd_pkg::NIBBLE_MAX) begin
								n_ml    = 24'(lz4bd_pkg::NIBBLE_MAX);
								n_phase = lz4bd_pkg::PH_MATCH_EXT;
							end else begin
								n_ml    = 24'(n_nib) + lz4bd_pkg::MIN_MATCH;
								n_phase = lz4bd_pkg::PH_MATCH;
							end
						end
						lz4bd_pkg::PH_MATCH_EXT: begin
							ml_sum  = {1'b0, n_ml} + 25'(in_byte);
							ml_sum4 = {1'b0, ml_sum[23:0]} + 25'(lz4bd_pkg::MIN_MATCH);
							if (ml_sum[24]) begin
								n_err = 1'b1; n_phase = lz4bd_pkg::PH_TOKEN;
								n_lit = '0; n_ml = '0;
							end else if (in_byte != lz4bd_pkg::EXT_MORE) begin
								if (ml_sum4[24]) begin
									n_err = 1'b1; n_phase = lz4bd_pkg::PH_TOKEN;
									n_lit = '0; n_ml = '0;
								end else begin
									n_ml    = ml_sum4[23:0];
									n_phase = lz4bd_pkg::PH_MATCH;
								end
							end else begin
								n_ml = ml_sum[23:0];
							end
						end
						default: begin
							n_phase = lz4bd_pkg::PH_TOKEN;
						end
					endcase
					if (block_end) begin
						n_end = 1'b1;
					end
				end
			end else if (!err_q && phase_q == lz4bd_pkg::PH_MATCH && ml_q != 24'd0) begin
				if (bw_q >= limit_q) begin
					n_err = 1'b1; n_phase = lz4bd_pkg::PH_TOKEN;
					n_lit = '0; n_ml = '0;
				end else begin
					wr_match = 1'b1;
					wr_addr  = ptr_q;
					n_bw     = bw_q + 24'd1;
					n_ptr    = (ptr_q == PTR_LAST) ? '0 : ptr_q + AW'(1);
					n_ml     = ml_q - 24'd1;
					if (ml_q == 24'd1) begin
						n_phase = lz4bd_pkg::PH_TOKEN;
					end
				end
			end
		end
		n_status.pending = !n_err && n_phase == lz4bd_pkg::PH_MATCH && n_ml != 24'd0;
		n_status.done    = n_end && !n_status.pending;
		n_status.err     = n_err;
		n_status.total   = n_bw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= lz4bd_pkg::LIMIT_RESET;
			phase_q <= lz4bd_pkg::PH_TOKEN;
			lit_q   <= '0;
			ml_q    <= '0;
			nib_q   <= '0;
			dist_q  <= '0;
			bw_q    <= '0;
			ptr_q   <= '0;
			err_q   <= 1'b0;
			end_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				limit_q <= cfg_wr_data;
			end
			phase_q <= n_phase;
			lit_q   <= n_lit;
			ml_q    <= n_ml;
			nib_q   <= n_nib;
			dist_q  <= n_dist;
			bw_q    <= n_bw;
			ptr_q   <= n_ptr;
			err_q   <= n_err;
			end_q   <= n_end;
		end
	end

	// history window
	lz4bd_ram #(
		.WIDTH(8),
		.DEPTH(WINDOW_BYTES)
	) u_hist (
		.clk  (clk),
		.we   (s1_move && s1_wr_q),
		.waddr(s1_addr_s1),
		.wdata(s1_data),
		.re   (wr_match),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	assign s1_data = !s1_match_q ? s1_lit_s1 : (s1_fwd_q ? s1_fwd_data_s1 : ram_rdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q     <= 1'b0;
			s1_wr_q    <= 1'b0;
			s1_match_q <= 1'b0;
			s1_fwd_q   <= 1'b0;
		end else if (accept) begin
			s1_v_q     <= 1'b1;
			s1_wr_q    <= wr_byte || wr_match;
			s1_match_q <= wr_match;
			// byte in flight to the same entry is written on this edge
			s1_fwd_q   <= wr_match && s1_v_q && s1_wr_q && s1_addr_s1 == rd_addr;
		end else if (s1_move) begin
			s1_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s1_lit_s1      <= in_byte;
			s1_fwd_data_s1 <= s1_data;
			s1_addr_s1     <= wr_addr;
			s1_status_s1   <= n_status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			out_wr_q <= 1'b0;
		end else if (s1_move) begin
			out_v_q  <= 1'b1;
			out_wr_q <= s1_wr_q;
		end else if (!res_stall) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_byte_q   <= s1_wr_q ? s1_data : 8'h00;
			out_status_q <= s1_status_s1;
		end
	end

	assign res_valid     = out_v_q;
	assign out_byte      = out_byte_q;
	assign out_valid     = out_wr_q;
	assign match_pending = out_status_q.pending;
	assign done_res      = out_status_q.done;
	assign error         = out_status_q.err;
	assign total_written = out_status_q.total;

`ifndef SYNTH
	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> s1_v_q)
		else $error("request stalled with empty stage");

	a_fwd_only_match: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_v_q && s1_fwd_q) |-> (s1_match_q && s1_wr_q))
		else $error("forward flag on a non-match byte");

	a_err_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(error && match_pending))
		else $error("match pending while in error");

	a_done_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(done_res && match_pending))
		else $error("done with match pending");

	a_byte_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && out_valid) |-> (total_written != 24'd0))
		else $error("byte emitted with zero count");
`endif

endmodule

// ===== rtl/lz4bd_ram.sv =====
module lz4bd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== tb/tb_lz4_block_decompressor.sv =====
`timescale 1ns / 100ps

module tb_lz4_block_decompressor;

	localparam int unsigned CYCLE_LIMIT = 3000000;

	typedef struct {
		logic       command;
		logic [7:0] in_byte;
		logic       block_end;
	} lz_req_t;

	typedef struct packed {
		logic [7:0]                  out_byte;
		logic                        out_valid;
		logic                        match_pending;
		logic                        done_res;
		logic                        error;
		logic [lz4bd_pkg::LEN_W-1:0] total_written;
	} lz_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [23:0] cfg_wr_data = '0;
	logic        cmd_valid = 1'b0;
	logic        cmd_stall;
	logic        command = 1'b0;
	logic [7:0]  in_byte = '0;
	logic        block_end = 1'b0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic [7:0]  out_byte;
	logic        out_valid;
	logic        match_pending;
	logic        done_res;
	logic        error;
	logic [23:0] total_written;

	lz4_block_decompressor dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.command(command),
		.in_byte(in_byte),
		.block_end(block_end),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.out_byte(out_byte),
		.out_valid(out_valid),
		.match_pending(match_pending),
		.done_res(done_res),
		.error(error),
		.total_written(total_written)
	);

	// decoder state as the block should hold it
	logic [7:0]                    hist_mem [0:65535];
	logic [lz4bd_pkg::LEN_W-1:0]   limit_reg = lz4bd_pkg::LIMIT_RESET;
	logic [lz4bd_pkg::PHASE_W-1:0] phase = lz4bd_pkg::PH_TOKEN;
	logic [lz4bd_pkg::LEN_W:0]     lit_cnt = '0;
	logic [lz4bd_pkg::LEN_W:0]     match_cnt = '0;
	logic [3:0]                    nib = '0;
	logic [15:0]                   distance = '0;
	logic [lz4bd_pkg::LEN_W-1:0]   written = '0;
	logic                          err_flag = 1'b0;
	logic                          end_seen = 1'b0;

	lz_req_t     queued_requests[$];
	lz_req_t     block_q[$];
	int          byte_marks[$];
	lz_result_t  expected_status[$];
	lz_req_t     issue_req;
	lz_result_t  want;
	int unsigned requests_sent = 0;
	int unsigned gap_left = 0;
	int unsigned stall_left = 0;
	int unsigned cycle_count = 0;
	bit          no_idle = 1'b0;
	bit          failed = 1'b0;

	function automatic void trip_error();
		err_flag = 1'b1;
		phase = lz4bd_pkg::PH_TOKEN;
		lit_cnt = '0;
		match_cnt = '0;
	endfunction

	function automatic bit emit_byte(input logic [7:0] v);
		if (written >= limit_reg) begin
			trip_error();
			return 1'b0;
		end
		hist_mem[written[15:0]] = v;
		written = written + 24'd1;
		return 1'b1;
	endfunction

	function automatic lz_result_t decompress_step(input logic cmd, input logic [7:0] b,
			input logic fin);
		lz_result_t r;
		logic [7:0] v;
		logic       got;
		logic       pend;
		v = '0;
		got = 1'b0;
		if (cmd == lz4bd_pkg::CMD_BYTE) begin
			if (end_seen) begin
				written = '0;
				err_flag = 1'b0;
				end_seen = 1'b0;
				phase = lz4bd_pkg::PH_TOKEN;
				lit_cnt = '0;
				match_cnt = '0;
				nib = '0;
				distance = '0;
			end
			if (err_flag) begin
				if (fin)
					end_seen = 1'b1;
			end else if (phase != lz4bd_pkg::PH_MATCH) begin
				case (phase)
					lz4bd_pkg::PH_TOKEN: begin
						lit_cnt = 25'(b[7:4]);
						nib = b[3:0];
						if (b[7:4] == lz4bd_pkg::NIBBLE_MAX)
							phase = lz4bd_pkg::PH_LIT_EXT;
						else if (b[7:4] != 4'd0)
							phase = lz4bd_pkg::PH_LITERALS;
						else
							phase = lz4bd_pkg::PH_OFF_LO;
					end
					lz4bd_pkg::PH_LIT_EXT: begin
						lit_cnt = lit_cnt + 25'(b);
						if (lit_cnt[lz4bd_pkg::LEN_W])
							trip_error();
						else if (b != lz4bd_pkg::EXT_MORE)
							phase = lz4bd_pkg::PH_LITERALS;
					end
					lz4bd_pkg::PH_LITERALS: begin
						if (emit_byte(b)) begin
							v = b;
							got = 1'b1;
							lit_cnt = lit_cnt - 25'd1;
							if (lit_cnt == '0)
								phase = lz4bd_pkg::PH_OFF_LO;
						end
					end
					lz4bd_pkg::PH_OFF_LO: begin
						distance = {8'd0, b};
						phase = lz4bd_pkg::PH_OFF_HI;
					end
					lz4bd_pkg::PH_OFF_HI: begin
						distance[15:8] = b;
						if (distance == 16'd0 || 24'(distance) > written) begin
							trip_error();
						end else if (nib == lz4bd_pkg::NIBBLE_MAX) begin
							match_cnt = 25'(lz4bd_pkg::NIBBLE_MAX);
							phase = lz4bd_pkg::PH_MATCH_EXT;
						end else begin
							match_cnt = 25'(lz4bd_pkg::MIN_MATCH) + 25'(nib);
							phase = lz4bd_pkg::PH_MATCH;
						end
					end
					default: begin
						match_cnt = match_cnt + 25'(b);
						if (match_cnt[lz4bd_pkg::LEN_W]) begin
							trip_error();
						end else if (b != lz4bd_pkg::EXT_MORE) begin
							match_cnt = match_cnt + 25'(lz4bd_pkg::MIN_MATCH);
							if (match_cnt[lz4bd_pkg::LEN_W])
								trip_error();
							else
								phase = lz4bd_pkg::PH_MATCH;
						end
					end
				endcase
				if (fin)
					end_seen = 1'b1;
			end
		end else if (!err_flag && phase == lz4bd_pkg::PH_MATCH && match_cnt != '0) begin
			v = hist_mem[16'(written[15:0] - distance)];
			if (emit_byte(v)) begin
				got = 1'b1;
				match_cnt = match_cnt - 25'd1;
				if (match_cnt == '0)
					phase = lz4bd_pkg::PH_TOKEN;
			end
		end
		pend = !err_flag && phase == lz4bd_pkg::PH_MATCH && match_cnt != '0;
		r.out_byte = got ? v : 8'd0;
		r.out_valid = got;
		r.match_pending = pend;
		r.done_res = end_seen && !pend;
		r.error = err_flag;
		r.total_written = written;
		return r;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic check_field(input string name, input logic [23:0] exp_v,
			input logic [23:0] act_v);
		if (act_v !== exp_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
			failed = 1'b1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			gap_left <= 0;
		end else begin
			if (cmd_valid && !cmd_stall)
				expected_status.push_back(decompress_step(command, in_byte, block_end));
			if (!cmd_valid || !cmd_stall) begin
				if (gap_left != 0) begin
					cmd_valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (queued_requests.size() != 0) begin
					issue_req = queued_requests.pop_front();
					cmd_valid <= 1'b1;
					command <= issue_req.command;
					in_byte <= issue_req.in_byte;
					block_end <= issue_req.block_end;
					gap_left <= pick_gap();
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
			stall_left <= 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (expected_status.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual byte %0h total %0h",
						$time, out_byte, total_written);
					failed = 1'b1;
				end else begin
					want = expected_status.pop_front();
					check_field("out_byte", 24'(want.out_byte), 24'(out_byte));
					check_field("out_valid", 24'(want.out_valid), 24'(out_valid));
					check_field("match_pending", 24'(want.match_pending), 24'(match_pending));
					check_field("done_res", 24'(want.done_res), 24'(done_res));
					check_field("error", 24'(want.error), 24'(error));
					check_field("total_written", want.total_written, total_written);
				end
			end
			if (no_idle) begin
				res_stall <= 1'b0;
				stall_left <= 0;
			end else if (stall_left != 0) begin
				res_stall <= 1'b1;
				stall_left <= stall_left - 1;
			end else begin
				res_stall <= 1'b0;
				if ($urandom_range(0, 3) == 0)
					stall_left <= pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		forever #6 clk = ~clk;
	end

	task automatic add_item(input logic cmd, input logic [7:0] b, input logic fin);
		if (cmd == lz4bd_pkg::CMD_BYTE)
			byte_marks.push_back(block_q.size());
		block_q.push_back('{cmd, b, fin});
	endtask

	task automatic send_block(input bit mark_end);
		if (mark_end && byte_marks.size() != 0)
			block_q[byte_marks[$]].block_end = 1'b1;
		foreach (block_q[i])
			queued_requests.push_back(block_q[i]);
		requests_sent += block_q.size();
		block_q.delete();
		byte_marks.delete();
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (queued_requests.size() != 0 || cmd_valid || expected_status.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_limit(input logic [23:0] v);
		wait_idle();
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		limit_reg = v;
	endtask

	task automatic add_length(input int unsigned e);
		repeat (e / 255) add_item(lz4bd_pkg::CMD_BYTE, lz4bd_pkg::EXT_MORE, 1'b0);
		add_item(lz4bd_pkg::CMD_BYTE, 8'(e % 255), 1'b0);
	endtask

	// mlen of zero gives a literal-only sequence
	task automatic add_sequence(input int unsigned lits, input int unsigned mlen,
			input int unsigned off);
		logic [3:0] hi;
		logic [3:0] lo;
		hi = (lits >= 15) ? lz4bd_pkg::NIBBLE_MAX : 4'(lits);
		lo = (mlen >= 19) ? lz4bd_pkg::NIBBLE_MAX : ((mlen >= 4) ? 4'(mlen - 4) : 4'd0);
		add_item(lz4bd_pkg::CMD_BYTE, {hi, lo}, 1'b0);
		if (hi == lz4bd_pkg::NIBBLE_MAX)
			add_length(lits - 15);
		repeat (lits) add_item(lz4bd_pkg::CMD_BYTE, 8'($urandom), 1'b0);
		if (mlen != 0) begin
			add_item(lz4bd_pkg::CMD_BYTE, off[7:0], 1'b0);
			add_item(lz4bd_pkg::CMD_BYTE, off[15:8], 1'b0);
			if (lo == lz4bd_pkg::NIBBLE_MAX)
				add_length(mlen - 19);
			for (int i = 0; i < mlen; i++) begin
				// stray byte while the copy is still running
				if (i == mlen - 1 && $urandom_range(0, 9) == 0)
					block_q.push_back('{lz4bd_pkg::CMD_BYTE, 8'($urandom), 1'b0});
				add_item(lz4bd_pkg::CMD_ADVANCE, 8'($urandom), 1'($urandom));
			end
			if ($urandom_range(0, 11) == 0)
				add_item(lz4bd_pkg::CMD_ADVANCE, 8'($urandom), 1'($urandom));
		end
	endtask

	task automatic add_random_block(input bit cut_short);
		int unsigned made;
		int unsigned lits;
		int unsigned mlen;
		int unsigned off;
		int unsigned reach;
		int unsigned nseq;
		int          cut;
		made = 0;
		nseq = $urandom_range(1, 4);
		repeat (nseq) begin
			lits = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 300) : $urandom_range(0, 10);
			if (made == 0 && lits == 0)
				lits = 1;
			mlen = ($urandom_range(0, 19) == 0) ? $urandom_range(19, 300) : $urandom_range(4, 18);
			reach = made + lits;
			if (reach > 65535)
				reach = 65535;
			case ($urandom_range(0, 15))
				0: off = 1;
				1: off = reach;
				2: off = ($urandom_range(0, 1) == 0) ? 0 : reach + 1;
				default: off = $urandom_range(1, reach);
			endcase
			add_sequence(lits, mlen, off);
			made += lits + mlen;
		end
		if ($urandom_range(0, 3) != 0)
			add_sequence($urandom_range(0, 8), 0, 0);
		if (cut_short) begin
			cut = byte_marks[$urandom_range(0, byte_marks.size() - 1)];
			while (block_q.size() > cut + 1)
				void'(block_q.pop_back());
			while (byte_marks[$] > cut)
				void'(byte_marks.pop_back());
		end
		send_block(1'b1);
	endtask

	// bring the decoder back to a block boundary from whatever state it is in
	task automatic close_block();
		int unsigned n;
		wait_idle();
		n = (!err_flag && phase == lz4bd_pkg::PH_MATCH) ? 32'(match_cnt) : 0;
		repeat (n) add_item(lz4bd_pkg::CMD_ADVANCE, 8'($urandom), 1'($urandom));
		if (!end_seen)
			add_item(lz4bd_pkg::CMD_BYTE, 8'($urandom), 1'b0);
		send_block(1'b1);
	endtask

	task automatic add_noise();
		repeat ($urandom_range(3, 20))
			block_q.push_back('{1'($urandom), 8'($urandom), $urandom_range(0, 5) == 0});
		send_block(1'b0);
		close_block();
	endtask

	initial begin
		logic [23:0] limits [6];
		int unsigned target;
		int unsigned r;
		limits = '{lz4bd_pkg::LIMIT_RESET, 24'd0, 24'd1, 24'd37, 24'($urandom_range(40, 400)),
			24'hFFFFFF};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// short block with a copy, a stray byte and an idle advance
		add_item(lz4bd_pkg::CMD_BYTE, 8'h21, 1'b0);
		add_item(lz4bd_pkg::CMD_BYTE, 8'h00, 1'b0);
		add_item(lz4bd_pkg::CMD_BYTE, 8'hFF, 1'b0);
		add_item(lz4bd_pkg::CMD_BYTE, 8'h02, 1'b0);
		add_item(lz4bd_pkg::CMD_BYTE, 8'h00, 1'b0);
		block_q.push_back('{lz4bd_pkg::CMD_BYTE, 8'hAA, 1'b1});
		repeat (5) add_item(lz4bd_pkg::CMD_ADVANCE, 8'hFF, 1'b1);
		add_item(lz4bd_pkg::CMD_ADVANCE, 8'h00, 1'b0);
		add_item(lz4bd_pkg::CMD_BYTE, 8'h00, 1'b1);
		// zero offset
		add_item(lz4bd_pkg::CMD_BYTE, 8'h10, 1'b0);
		add_item(lz4bd_pkg::CMD_BYTE, 8'h5A, 1'b0);
		add_item(lz4bd_pkg::CMD_BYTE, 8'h00, 1'b0);
		add_item(lz4bd_pkg::CMD_BYTE, 8'h00, 1'b0);
		add_item(lz4bd_pkg::CMD_ADVANCE, 8'h00, 1'b0);
		add_item(lz4bd_pkg::CMD_BYTE, 8'h37, 1'b1);
		// offset beyond what was written
		add_item(lz4bd_pkg::CMD_BYTE, 8'h01, 1'b0);
		add_item(lz4bd_pkg::CMD_BYTE, 8'h05, 1'b0);
		add_item(lz4bd_pkg::CMD_BYTE, 8'h00, 1'b0);
		add_item(lz4bd_pkg::CMD_BYTE, 8'hF0, 1'b1);
		// block cut off inside the literal length
		add_item(lz4bd_pkg::CMD_BYTE, 8'hF0, 1'b1);
		send_block(1'b0);

		for (int p = 0; p < 6; p++) begin
			if (p != 0)
				set_limit(limits[p]);
			target = requests_sent + 40;
			while (requests_sent < target) begin
				no_idle = ($urandom_range(0, 4) == 0);
				r = $urandom_range(0, 19);
				if (r < 3)
					add_noise();
				else
					add_random_block(r < 5);
			end
		end

		no_idle = 1'b1;
		// extended lengths with a copy at distance one, then the farthest offset
		add_sequence(20, 40, 1);
		add_sequence(4, 4, 65535);
		add_sequence(2, 0, 0);
		send_block(1'b1);

		wait_idle();
		repeat (10) @(posedge clk);
		if (!failed)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
